// ===== design/lcdseq_pkg.sv =====
// package: shared types, codes and constants of the lcd nibble write sequencer
`default_nettype none
package lcdseq_pkg;

    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int ROW_W    = 2;
    localparam int COL_W    = 6;
    localparam int NIBBLE_W = 4;
    localparam int WAIT_W   = 8;
    localparam int ADDR_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [KIND_W-1:0] KIND_CMD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MOVE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE  = 2'd1;

    localparam logic [WAIT_W-1:0] SETTLE_RESET = 8'd10;
    localparam logic [WAIT_W-1:0] PHASE_RESET  = 8'd1;

    localparam logic SET_DDRAM_BIT = 1'b1;

    typedef struct packed {
        logic              rs;
        logic [BYTE_W-1:0] value;
    } lcdseq_entry_t;

    function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] r);
        logic [ADDR_W-1:0] b;
        unique case (r)
            2'd0: b = 7'h00;
            2'd1: b = 7'h40;
            2'd2: b = 7'h14;
            2'd3: b = 7'h54;
            default: b = 7'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== design/lcdseq_if.sv =====
// interfaces: request, pin snapshot and configuration channels
`default_nettype none
interface lcdseq_req_if;
    logic                              valid;
    logic                              ready;
    logic [lcdseq_pkg::KIND_W-1:0]     kind;
    logic [lcdseq_pkg::BYTE_W-1:0]     byte_value;
    logic [lcdseq_pkg::ROW_W-1:0]      row;
    logic [lcdseq_pkg::COL_W-1:0]      column;

    modport source (output valid, kind, byte_value, row, column, input ready);
    modport sink   (input valid, kind, byte_value, row, column, output ready);
endinterface

interface lcdseq_pin_if;
    logic                              valid;
    logic                              ready;
    logic                              reg_select;
    logic                              enable_pin;
    logic [lcdseq_pkg::NIBBLE_W-1:0]   data_nibble;
    logic [lcdseq_pkg::WAIT_W-1:0]     wait_ms;
    logic                              last;

    modport source (output valid, reg_select, enable_pin, data_nibble, wait_ms, last,
                    input ready);
    modport sink   (input valid, reg_select, enable_pin, data_nibble, wait_ms, last,
                    output ready);
endinterface

interface lcdseq_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lcdseq_pkg::CFG_IDX_W-1:0]    index;
    logic [lcdseq_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/lcdseq_front.sv =====
// front end: accepts requests, drops unused kinds, builds the byte and rs level
`default_nettype none
module lcdseq_front
(
    lcdseq_req_if.sink                   req,
    output logic                         push,
    output lcdseq_pkg::lcdseq_entry_t    push_entry,
    input  logic                         push_ready
);

    logic [lcdseq_pkg::ADDR_W-1:0] addr;

    assign addr = lcdseq_pkg::row_base(req.row)
                + {{(lcdseq_pkg::ADDR_W-lcdseq_pkg::COL_W){1'b0}}, req.column};

    assign req.ready = push_ready;

    always_comb
    begin
        push             = 1'b0;
        push_entry.rs    = 1'b0;
        push_entry.value = req.byte_value;
        unique case (req.kind)
            lcdseq_pkg::KIND_CMD:
            begin
                push = req.valid;
            end
            lcdseq_pkg::KIND_CHAR:
            begin
                push          = req.valid;
                push_entry.rs = 1'b1;
            end
            lcdseq_pkg::KIND_MOVE:
            begin
                push             = req.valid;
                push_entry.value = {lcdseq_pkg::SET_DDRAM_BIT, addr};
            end
            lcdseq_pkg::KIND_NONE:
            begin
                push = 1'b0;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/lcdseq_queue.sv =====
// short fifo between the front end and the transfer sequencer
`default_nettype none
module lcdseq_queue
#(
    parameter int DEPTH = lcdseq_pkg::QUEUE_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  lcdseq_pkg::lcdseq_entry_t    push_entry,
    output logic                         push_ready,
    input  logic                         pop,
    output logic                         pop_valid,
    output lcdseq_pkg::lcdseq_entry_t    pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lcdseq_pkg::lcdseq_entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// ===== design/lcdseq_back.sv =====
// back end: steps one byte through eight pin snapshots into an output register
`default_nettype none
module lcdseq_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  lcdseq_pkg::lcdseq_entry_t       q_entry,
    output logic                            q_pop,
    input  logic [lcdseq_pkg::WAIT_W-1:0]   settle_wait,
    input  logic [lcdseq_pkg::WAIT_W-1:0]   phase_wait,
    lcdseq_pin_if.source                    pins
);

    localparam logic [2:0] STEP_RS      = 3'd1;
    localparam logic [2:0] STEP_E_HI1   = 3'd2;
    localparam logic [2:0] STEP_D_HI    = 3'd3;
    localparam logic [2:0] STEP_E_LO1   = 3'd4;
    localparam logic [2:0] STEP_E_HI2   = 3'd5;
    localparam logic [2:0] STEP_D_LO    = 3'd6;
    localparam logic [2:0] STEP_E_LO2   = 3'd7;
    localparam logic [2:0] STEP_SETTLE  = 3'd0;

    logic                               busy_reg, busy_next;
    logic [2:0]                         step_reg, step_next;
    lcdseq_pkg::lcdseq_entry_t          cur_reg, cur_next;
    logic                               valid_reg, valid_next;
    logic                               rs_reg, rs_next;
    logic                               e_reg, e_next;
    logic [lcdseq_pkg::NIBBLE_W-1:0]    d_reg, d_next;
    logic [lcdseq_pkg::WAIT_W-1:0]      wait_reg, wait_next;
    logic                               last_reg, last_next;
    logic                               advance;

    assign advance = !valid_reg || pins.ready;
    assign q_pop   = advance && !busy_reg && q_valid;

    assign pins.valid       = valid_reg;
    assign pins.reg_select  = rs_reg;
    assign pins.enable_pin  = e_reg;
    assign pins.data_nibble = d_reg;
    assign pins.wait_ms     = wait_reg;
    assign pins.last        = last_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        cur_next   = cur_reg;
        valid_next = valid_reg;
        rs_next    = rs_reg;
        e_next     = e_reg;
        d_next     = d_reg;
        wait_next  = wait_reg;
        last_next  = last_reg;
        if (advance)
        begin
            if (q_pop)
            begin
                valid_next = 1'b1;
                wait_next  = settle_wait;
                last_next  = 1'b0;
                cur_next   = q_entry;
                busy_next  = 1'b1;
                step_next  = STEP_RS;
            end
            else if (busy_reg)
            begin
                valid_next = 1'b1;
                wait_next  = phase_wait;
                last_next  = 1'b0;
                step_next  = step_reg + 1'b1;
                unique case (step_reg)
                    STEP_RS:     rs_next = cur_reg.rs;
                    STEP_E_HI1:  e_next  = 1'b1;
                    STEP_D_HI:   d_next  = cur_reg.value[7:4];
                    STEP_E_LO1:  e_next  = 1'b0;
                    STEP_E_HI2:  e_next  = 1'b1;
                    STEP_D_LO:   d_next  = cur_reg.value[3:0];
                    STEP_E_LO2:
                    begin
                        e_next    = 1'b0;
                        last_next = 1'b1;
                        busy_next = 1'b0;
                        step_next = STEP_SETTLE;
                    end
                    STEP_SETTLE: busy_next = 1'b0;
                    default:     busy_next = 1'b0;
                endcase
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= STEP_SETTLE;
            valid_reg <= 1'b0;
            rs_reg    <= 1'b0;
            e_reg     <= 1'b0;
            d_reg     <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
            rs_reg    <= rs_next;
            e_reg     <= e_next;
            d_reg     <= d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        wait_reg <= wait_next;
        last_reg <= last_next;
    end

endmodule
`default_nettype wire

// ===== design/char_lcd_nibble_write_sequencer.sv =====
// top level: lcd nibble write sequencer with configuration registers
//
// channel  role  contents
// cmd      sink  kind, byte_value, row, column
// pins     src   reg_select, enable_pin, data_nibble, wait_ms, last
// cfg      sink  index, data (always ready)
//
// each byte gives eight snapshots, one per cycle unless the output stalls,
// stepped by the back end step counter; unused kinds give no snapshot. the
// front end takes requests into a QUEUE_DEPTH entry fifo until it is full
// while output stalls. reset clears pin levels to 0, waits to 10 and 1.
`default_nettype none
module char_lcd_nibble_write_sequencer
#(
    parameter int QUEUE_DEPTH = lcdseq_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    lcdseq_req_if.sink    cmd,
    lcdseq_pin_if.source  pins,
    lcdseq_cfg_if.sink    cfg
);

    logic [lcdseq_pkg::WAIT_W-1:0] settle_reg;
    logic [lcdseq_pkg::WAIT_W-1:0] phase_reg;

    logic                          push;
    lcdseq_pkg::lcdseq_entry_t     push_entry;
    logic                          push_ready;
    logic                          q_pop;
    logic                          q_valid;
    lcdseq_pkg::lcdseq_entry_t     q_entry;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= lcdseq_pkg::SETTLE_RESET;
            phase_reg  <= lcdseq_pkg::PHASE_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == lcdseq_pkg::CFG_SETTLE)
            begin
                settle_reg <= cfg.data;
            end
            else if (cfg.index == lcdseq_pkg::CFG_PHASE)
            begin
                phase_reg <= cfg.data;
            end
        end
    end

    lcdseq_front u_front
    (
        .req        (cmd),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    lcdseq_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry)
    );

    lcdseq_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop),
        .settle_wait (settle_reg),
        .phase_wait  (phase_reg),
        .pins        (pins)
    );

endmodule
`default_nettype wire
